@@ rtl/rbas_pkg.sv @@
// Shared types, constants and helpers for the rigid-body angular step block.
// No dependencies; imported by the divider, square root, top-level and checker modules of the block.
package rbas_pkg;

	localparam int unsigned SWEEP_W     = 4;
	localparam logic [SWEEP_W-1:0] SWEEP_RESET = 4'd5;
	localparam int unsigned S_DATA_W    = 320;
	localparam int unsigned M_DATA_W    = 224;
	localparam logic signed [31:0] ONE_Q30 = 32'sh4000_0000;
	localparam logic signed [31:0] MAX32   = 32'sh7FFF_FFFF;
	localparam logic signed [31:0] MIN32   = 32'sh8000_0000;
	localparam int unsigned DIV_STEPS  = 31;
	localparam int unsigned SQRT_STEPS = 32;

	typedef struct packed {
		logic [63:0] dividend;
		logic [31:0] den;
		logic        neg;
	} div_req_t;

	typedef enum logic [20:0] {
		ST_IDLE      = 21'h000001,
		ST_RHS_MUL   = 21'h000002,
		ST_RHS_WB    = 21'h000004,
		ST_SW_MUL1   = 21'h000008,
		ST_SW_MUL2   = 21'h000010,
		ST_SW_ACC    = 21'h000020,
		ST_DIV_GO    = 21'h000040,
		ST_DIV_WAIT  = 21'h000080,
		ST_SPIN      = 21'h000100,
		ST_Q_MUL     = 21'h000200,
		ST_Q_ACC     = 21'h000400,
		ST_Q_DT      = 21'h000800,
		ST_Q_U       = 21'h001000,
		ST_NORM      = 21'h002000,
		ST_SQ_MUL    = 21'h004000,
		ST_SQ_ACC    = 21'h008000,
		ST_SQRT_GO   = 21'h010000,
		ST_SQRT_WAIT = 21'h020000,
		ST_QD_GO     = 21'h040000,
		ST_QD_WAIT   = 21'h080000,
		ST_OUT       = 21'h100000
	} state_t;

	function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
		logic signed [31:0] r;
		if (v > 66'sh0_7FFF_FFFF)
			r = MAX32;
		else if (v < -66'sh0_8000_0000)
			r = MIN32;
		else
			r = v[31:0];
		return r;
	endfunction

endpackage

@@ rtl/rbas_mul.sv @@
// Shared signed multiplier with a registered product.
// Does not import rbas_pkg; none of its items are used.
module rbas_mul (
	input  logic               clk,
	input  logic signed [32:0] a,
	input  logic signed [32:0] b,
	output logic signed [65:0] p_q
);
	always_ff @(posedge clk) begin
		p_q <= a * b;
	end
endmodule

@@ rtl/rbas_div.sv @@
// Iterative restoring divider, one quotient bit per cycle, saturating to 32 bits signed.
// Depends on rbas_pkg (div_req_t, limits, step count).
module rbas_div (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  rbas_pkg::div_req_t  req,
	output logic                done,
	output logic signed [31:0]  quot
);
	import rbas_pkg::*;

	logic        busy_q;
	logic [4:0]  cnt_q;
	logic [30:0] dvd_q;
	logic [31:0] rem_q;
	logic [31:0] den_q;
	logic [30:0] q_q;
	logic        neg_q;
	logic        done_q;
	logic signed [31:0] quot_q;
	logic [32:0] trial;
	logic [32:0] diff;
	logic        ovf;

	assign ovf   = req.dividend >= {1'b0, req.den, 31'b0};
	assign trial = {rem_q, dvd_q[30]};
	assign diff  = trial - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				neg_q <= req.neg;
				if (req.den == '0) begin
					done_q <= 1'b1;
					quot_q <= (req.dividend == '0) ? '0 : (req.neg ? MIN32 : MAX32);
				end else if (ovf) begin
					done_q <= 1'b1;
					quot_q <= req.neg ? MIN32 : MAX32;
				end else begin
					busy_q <= 1'b1;
					cnt_q  <= 5'(DIV_STEPS);
					rem_q  <= req.dividend[62:31];
					dvd_q  <= req.dividend[30:0];
					den_q  <= req.den;
					q_q    <= '0;
				end
			end else if (busy_q) begin
				dvd_q <= {dvd_q[29:0], 1'b0};
				if (!diff[32]) begin
					rem_q <= diff[31:0];
					q_q   <= {q_q[29:0], 1'b1};
				end else begin
					rem_q <= trial[31:0];
					q_q   <= {q_q[29:0], 1'b0};
				end
				cnt_q <= cnt_q - 5'd1;
				if (cnt_q == 5'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
					quot_q <= neg_q ? -$signed({1'b0, q_q[29:0], !diff[32]})
					                : $signed({1'b0, q_q[29:0], !diff[32]});
				end
			end
		end
	end

	assign done = done_q;
	assign quot = quot_q;
endmodule

@@ rtl/rbas_isqrt.sv @@
// Iterative integer square root of a 64-bit value, two radicand bits per cycle.
// Depends on rbas_pkg (step count).
module rbas_isqrt (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] val,
	output logic        done,
	output logic [31:0] root
);
	import rbas_pkg::*;

	logic        busy_q;
	logic        done_q;
	logic [5:0]  cnt_q;
	logic [63:0] v_q;
	logic [63:0] r_q;
	logic [63:0] bit_q;
	logic [63:0] tst;

	assign tst = r_q + bit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 6'(SQRT_STEPS);
				v_q    <= val;
				r_q    <= '0;
				bit_q  <= 64'h4000_0000_0000_0000;
			end else if (busy_q) begin
				if (v_q >= tst) begin
					v_q <= v_q - tst;
					r_q <= (r_q >> 1) + bit_q;
				end else begin
					r_q <= r_q >> 1;
				end
				bit_q <= bit_q >> 2;
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done = done_q;
	assign root = r_q[31:0];
endmodule

@@ rtl/rigid_body_angular_step.sv @@
// Rigid-body angular step: Gauss-Seidel inertia solve, spin update, quaternion integration.
// Depends on rbas_pkg, rbas_mul, rbas_div, rbas_isqrt.
//
// Input beats on s_*: dt, torque and the symmetric inertia tensor. Each beat yields one
// output beat on m_*: new angular velocity and unit orientation quaternion.
// cfg_* writes sweep_count (4 bits); ready is always high, write only while idle.
// One shared multiplier, a bit-serial divider (which skips its iteration when it
// saturates at once) and a bit-serial square root run under one sequencer. The time
// from the input beat to m_tvalid grows with sweep_count and with each renormalizing
// shift, and shrinks for each division that saturates at once and when the quaternion
// collapses to zero (then the square root and the final divisions are skipped). A new
// input can be taken in the cycle after the result is loaded.
// s_tready is high only while idle; a finished result sits in an output register, so
// the next item is taken while that beat waits. If the output register is still full
// when the next result is done, the sequencer holds until m_tready frees it.
// Reset: sweep_count = 5, angular velocity zero, orientation identity, no beat pending.
module rigid_body_angular_step (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// time_step[30:0] torque_x[62:31] torque_y[94:63] torque_z[126:95]
	// inertia_xx[157:127] inertia_yy[188:158] inertia_zz[219:189]
	// inertia_xy[251:220] inertia_xz[283:252] inertia_yz[315:284], zero pad
	input  logic [rbas_pkg::S_DATA_W-1:0] s_tdata,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// spin_x, spin_y, spin_z, quat_w, quat_i, quat_j, quat_k, 32 bits each
	output logic [rbas_pkg::M_DATA_W-1:0] m_tdata,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [rbas_pkg::SWEEP_W-1:0]  cfg_data
);
	import rbas_pkg::*;

	state_t state_q;

	logic [SWEEP_W-1:0] sweep_q;
	logic [SWEEP_W-1:0] sweep_cnt_q;
	logic [30:0]        dt_q;
	logic signed [31:0] tq_q [3];
	logic [30:0]        diag_q [3];
	logic signed [31:0] ixy_q, ixz_q, iyz_q;
	logic signed [31:0] rhs_q [3];
	logic signed [31:0] x_q [3];
	logic signed [31:0] spin_q [3];
	logic signed [31:0] orient_q [4];
	logic signed [48:0] u_q [4];
	logic signed [49:0] acc_q;
	logic [48:0]        mx_q;
	logic [63:0]        sum_q;
	logic [31:0]        root_q;
	logic [1:0]         k_q, j_q, r_q;
	logic [M_DATA_W-1:0] out_q;
	logic               m_tvalid_q;
	logic               out_load;

	logic signed [32:0] mul_a, mul_b;
	logic signed [65:0] mul_p;
	logic signed [49:0] prod16;
	logic signed [48:0] prod17;

	logic               div_start;
	div_req_t           div_req;
	logic               div_done;
	logic signed [31:0] div_quot;
	logic               sq_start;
	logic               sq_done;
	logic [31:0]        sq_root;

	logic signed [31:0] off_a, off_b, xv_a, xv_b, rhs_r;
	logic [30:0]        diag_r;
	logic signed [31:0] tw, tq;
	logic               term_neg;
	logic signed [32:0] p_clamp;
	logic signed [49:0] acc_mag;
	logic signed [48:0] u_new;
	logic [48:0]        u_abs;
	logic signed [48:0] u_k;
	logic [48:0]        uk_abs;

	rbas_mul u_mul (.clk(clk), .a(mul_a), .b(mul_b), .p_q(mul_p));

	rbas_div u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .req(div_req),
		.done(div_done), .quot(div_quot)
	);

	rbas_isqrt u_sqrt (
		.clk(clk), .arst_n(arst_n), .start(sq_start), .val(sum_q),
		.done(sq_done), .root(sq_root)
	);

	assign prod16 = mul_p[65:16];
	assign prod17 = mul_p[65:17];

	always_comb begin
		unique case (r_q)
			2'd0: begin
				off_a = ixy_q; xv_a = x_q[1]; off_b = ixz_q; xv_b = x_q[2];
				diag_r = diag_q[0]; rhs_r = rhs_q[0];
			end
			2'd1: begin
				off_a = ixy_q; xv_a = x_q[0]; off_b = iyz_q; xv_b = x_q[2];
				diag_r = diag_q[1]; rhs_r = rhs_q[1];
			end
			default: begin
				off_a = ixz_q; xv_a = x_q[0]; off_b = iyz_q; xv_b = x_q[1];
				diag_r = diag_q[2]; rhs_r = rhs_q[2];
			end
		endcase
	end

	always_comb begin
		unique case ({k_q, j_q})
			4'h0: begin tw = spin_q[0]; tq = orient_q[1]; term_neg = 1'b1; end
			4'h1: begin tw = spin_q[1]; tq = orient_q[2]; term_neg = 1'b1; end
			4'h2: begin tw = spin_q[2]; tq = orient_q[3]; term_neg = 1'b1; end
			4'h4: begin tw = spin_q[0]; tq = orient_q[0]; term_neg = 1'b0; end
			4'h5: begin tw = spin_q[1]; tq = orient_q[3]; term_neg = 1'b0; end
			4'h6: begin tw = spin_q[2]; tq = orient_q[2]; term_neg = 1'b1; end
			4'h8: begin tw = spin_q[1]; tq = orient_q[0]; term_neg = 1'b0; end
			4'h9: begin tw = spin_q[0]; tq = orient_q[3]; term_neg = 1'b1; end
			4'hA: begin tw = spin_q[2]; tq = orient_q[1]; term_neg = 1'b0; end
			4'hC: begin tw = spin_q[2]; tq = orient_q[0]; term_neg = 1'b0; end
			4'hD: begin tw = spin_q[0]; tq = orient_q[2]; term_neg = 1'b0; end
			4'hE: begin tw = spin_q[1]; tq = orient_q[1]; term_neg = 1'b1; end
			default: begin tw = '0; tq = '0; term_neg = 1'b0; end
		endcase
	end

	always_comb begin
		if (acc_q > 50'sh0_FFFF_FFFF)
			p_clamp = 33'sh0_FFFF_FFFF;
		else if (acc_q < -50'sh1_0000_0000)
			p_clamp = -33'sh1_0000_0000;
		else
			p_clamp = acc_q[32:0];
	end

	always_comb begin
		unique case (k_q)
			2'd0: u_k = u_q[0];
			2'd1: u_k = u_q[1];
			2'd2: u_k = u_q[2];
			default: u_k = u_q[3];
		endcase
	end

	assign acc_mag = acc_q[49] ? -acc_q : acc_q;
	assign u_new   = 49'(orient_q[k_q]) + prod17;
	assign u_abs   = u_new[48] ? 49'(-u_new) : 49'(u_new);
	assign uk_abs  = u_k[48] ? 49'(-u_k) : 49'(u_k);

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (state_q)
			ST_RHS_MUL: begin
				mul_a = $signed({2'b00, dt_q});
				mul_b = 33'(tq_q[k_q]);
			end
			ST_SW_MUL1: begin mul_a = 33'(off_a); mul_b = 33'(xv_a); end
			ST_SW_MUL2: begin mul_a = 33'(off_b); mul_b = 33'(xv_b); end
			ST_Q_MUL:   begin mul_a = 33'(tw); mul_b = 33'(tq); end
			ST_Q_DT: begin
				mul_a = $signed({2'b00, dt_q});
				mul_b = p_clamp;
			end
			ST_SQ_MUL: begin
				mul_a = 33'($signed(u_k[31:0]));
				mul_b = 33'($signed(u_k[31:0]));
			end
			default: begin mul_a = '0; mul_b = '0; end
		endcase
	end

	always_comb begin
		div_start = (state_q == ST_DIV_GO) || (state_q == ST_QD_GO);
		if (state_q == ST_QD_GO) begin
			div_req.dividend = {uk_abs[33:0], 30'b0};
			div_req.den      = root_q;
			div_req.neg      = u_k[48];
		end else begin
			div_req.dividend = {acc_mag[47:0], 16'b0};
			div_req.den      = {1'b0, diag_r};
			div_req.neg      = acc_q[49];
		end
	end

	assign sq_start  = (state_q == ST_SQRT_GO) && (sum_q != '0);
	assign s_tready  = (state_q == ST_IDLE);
	assign cfg_ready = 1'b1;
	assign m_tvalid  = m_tvalid_q;
	assign m_tdata   = out_q;
	assign out_load  = (state_q == ST_OUT) && (!m_tvalid_q || m_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sweep_q <= SWEEP_RESET;
		end else if (cfg_valid) begin
			sweep_q <= cfg_data;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			dt_q      <= s_tdata[30:0];
			tq_q[0]   <= s_tdata[62:31];
			tq_q[1]   <= s_tdata[94:63];
			tq_q[2]   <= s_tdata[126:95];
			diag_q[0] <= s_tdata[157:127];
			diag_q[1] <= s_tdata[188:158];
			diag_q[2] <= s_tdata[219:189];
			ixy_q     <= s_tdata[251:220];
			ixz_q     <= s_tdata[283:252];
			iyz_q     <= s_tdata[315:284];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			spin_q[0]   <= '0;
			spin_q[1]   <= '0;
			spin_q[2]   <= '0;
			orient_q[0] <= ONE_Q30;
			orient_q[1] <= '0;
			orient_q[2] <= '0;
			orient_q[3] <= '0;
			m_tvalid_q  <= 1'b0;
			k_q         <= '0;
			j_q         <= '0;
			r_q         <= '0;
			sweep_cnt_q <= '0;
		end else begin
			if (out_load)
				m_tvalid_q <= 1'b1;
			else if (m_tvalid_q && m_tready)
				m_tvalid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						k_q     <= '0;
						state_q <= ST_RHS_MUL;
					end
				end
				ST_RHS_MUL: state_q <= ST_RHS_WB;
				ST_RHS_WB: begin
					rhs_q[k_q] <= sat32(66'(prod16));
					x_q[k_q]   <= sat32(66'(prod16));
					if (k_q == 2'd2) begin
						r_q         <= '0;
						sweep_cnt_q <= '0;
						state_q     <= (sweep_q == '0) ? ST_SPIN : ST_SW_MUL1;
					end else begin
						k_q     <= k_q + 2'd1;
						state_q <= ST_RHS_MUL;
					end
				end
				ST_SW_MUL1: state_q <= ST_SW_MUL2;
				ST_SW_MUL2: begin
					acc_q   <= 50'(rhs_r) - prod16;
					state_q <= ST_SW_ACC;
				end
				ST_SW_ACC: begin
					acc_q   <= acc_q - prod16;
					state_q <= ST_DIV_GO;
				end
				ST_DIV_GO: state_q <= ST_DIV_WAIT;
				ST_DIV_WAIT: begin
					if (div_done) begin
						x_q[r_q] <= div_quot;
						if (r_q == 2'd2) begin
							r_q <= '0;
							if (sweep_cnt_q + 4'd1 == sweep_q) begin
								state_q <= ST_SPIN;
							end else begin
								sweep_cnt_q <= sweep_cnt_q + 4'd1;
								state_q     <= ST_SW_MUL1;
							end
						end else begin
							r_q     <= r_q + 2'd1;
							state_q <= ST_SW_MUL1;
						end
					end
				end
				ST_SPIN: begin
					spin_q[0] <= sat32(66'(spin_q[0]) + 66'(x_q[0]));
					spin_q[1] <= sat32(66'(spin_q[1]) + 66'(x_q[1]));
					spin_q[2] <= sat32(66'(spin_q[2]) + 66'(x_q[2]));
					k_q       <= '0;
					j_q       <= '0;
					acc_q     <= '0;
					mx_q      <= '0;
					state_q   <= ST_Q_MUL;
				end
				ST_Q_MUL: state_q <= ST_Q_ACC;
				ST_Q_ACC: begin
					acc_q <= term_neg ? acc_q - prod16 : acc_q + prod16;
					if (j_q == 2'd2) begin
						j_q     <= '0;
						state_q <= ST_Q_DT;
					end else begin
						j_q     <= j_q + 2'd1;
						state_q <= ST_Q_MUL;
					end
				end
				ST_Q_DT: state_q <= ST_Q_U;
				ST_Q_U: begin
					u_q[k_q] <= u_new;
					if (u_abs > mx_q)
						mx_q <= u_abs;
					acc_q <= '0;
					if (k_q == 2'd3) begin
						state_q <= ST_NORM;
					end else begin
						k_q     <= k_q + 2'd1;
						state_q <= ST_Q_MUL;
					end
				end
				ST_NORM: begin
					if (mx_q[48:31] != '0) begin
						mx_q   <= mx_q >> 1;
						u_q[0] <= u_q[0] >>> 1;
						u_q[1] <= u_q[1] >>> 1;
						u_q[2] <= u_q[2] >>> 1;
						u_q[3] <= u_q[3] >>> 1;
					end else begin
						k_q     <= '0;
						sum_q   <= '0;
						state_q <= ST_SQ_MUL;
					end
				end
				ST_SQ_MUL: state_q <= ST_SQ_ACC;
				ST_SQ_ACC: begin
					sum_q <= sum_q + mul_p[63:0];
					if (k_q == 2'd3) begin
						state_q <= ST_SQRT_GO;
					end else begin
						k_q     <= k_q + 2'd1;
						state_q <= ST_SQ_MUL;
					end
				end
				ST_SQRT_GO: begin
					if (sum_q == '0) begin
						orient_q[0] <= ONE_Q30;
						orient_q[1] <= '0;
						orient_q[2] <= '0;
						orient_q[3] <= '0;
						state_q     <= ST_OUT;
					end else begin
						state_q <= ST_SQRT_WAIT;
					end
				end
				ST_SQRT_WAIT: begin
					if (sq_done) begin
						root_q  <= sq_root;
						k_q     <= '0;
						state_q <= ST_QD_GO;
					end
				end
				ST_QD_GO: state_q <= ST_QD_WAIT;
				ST_QD_WAIT: begin
					if (div_done) begin
						orient_q[k_q] <= div_quot;
						if (k_q == 2'd3) begin
							state_q <= ST_OUT;
						end else begin
							k_q     <= k_q + 2'd1;
							state_q <= ST_QD_GO;
						end
					end
				end
				ST_OUT: begin
					if (out_load) begin
						out_q   <= {orient_q[3], orient_q[2], orient_q[1], orient_q[0],
						            spin_q[2], spin_q[1], spin_q[0]};
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule

@@ rtl/rbas_checker.sv @@
// Port-level checks for rigid_body_angular_step, attached by bind.
// Depends on rbas_pkg (data widths).
module rbas_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          s_tvalid,
	input logic                          s_tready,
	input logic                          m_tvalid,
	input logic                          m_tready,
	input logic [rbas_pkg::M_DATA_W-1:0] m_tdata
);
	import rbas_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("output beat changed while stalled");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready ##1 !s_tready)
		else $error("input taken again too soon");

	a_out_known: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !$isunknown(m_tdata))
		else $error("output beat carries unknown bits");
endmodule

bind rigid_body_angular_step rbas_checker u_rbas_checker (
	.clk(clk), .arst_n(arst_n), .s_tvalid(s_tvalid), .s_tready(s_tready),
	.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
);
